/* hdl/bpd_pkg.sv */
package bpd_pkg;

    localparam int SAMPLE_W = 8;
    localparam int CODE_W   = 3;
    localparam int CNT_W    = 4;
    localparam int IDX_W    = 3;
    localparam int DATA_W   = 8;

    localparam logic [CNT_W-1:0] LONG_PRESS_TICKS = 4'd8;

    typedef logic [SAMPLE_W-1:0] sample_t;
    typedef logic [CODE_W-1:0]   code_t;
    typedef logic [CNT_W-1:0]    count_t;
    typedef logic [IDX_W-1:0]    reg_index_t;
    typedef logic [DATA_W-1:0]   reg_data_t;

    localparam code_t CODE_NONE  = 3'd0;
    localparam code_t CODE_BTN1  = 3'd1;
    localparam code_t CODE_BTN2  = 3'd2;
    localparam code_t CODE_BTN3  = 3'd3;
    localparam code_t CODE_BTN4  = 3'd4;
    localparam code_t CODE_SHORT = 3'd1;
    localparam code_t CODE_LONG  = 3'd2;
    localparam code_t CODE_HELD  = 3'd4;

    typedef enum logic [IDX_W-1:0] {
        REG_LADDER_MODE = 3'd0,
        REG_LEVEL_NONE  = 3'd1,
        REG_LEVEL_FOUR  = 3'd2,
        REG_LEVEL_THREE = 3'd3,
        REG_LEVEL_TWO   = 3'd4
    } reg_sel_t;

    typedef struct packed {
        logic    ladder_mode;
        sample_t level_none;
        sample_t level_four;
        sample_t level_three;
        sample_t level_two;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        ladder_mode: 1'b0,
        level_none:  8'd224,
        level_four:  8'd181,
        level_three: 8'd149,
        level_two:   8'd64
    };

endpackage

/* hdl/bpd_in_if.sv */
interface bpd_in_if;
    logic                   valid;
    logic                   ready;
    logic [bpd_pkg::SAMPLE_W-1:0] ladder_sample;
    logic                   pin_level;

    modport source (output valid, output ladder_sample, output pin_level, input ready);
    modport sink   (input valid, input ladder_sample, input pin_level, output ready);
endinterface

/* hdl/bpd_out_if.sv */
interface bpd_out_if;
    logic                       valid;
    logic                       ready;
    logic [bpd_pkg::CODE_W-1:0] button_code;

    modport source (output valid, output button_code, input ready);
    modport sink   (input valid, input button_code, output ready);
endinterface

/* hdl/bpd_cfg_if.sv */
interface bpd_cfg_if;
    logic                       valid;
    logic                       ready;
    logic [bpd_pkg::IDX_W-1:0]  index;
    logic [bpd_pkg::DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

/* hdl/bpd_cfg_regs.sv */
module bpd_cfg_regs (
    input  logic          clk,
    input  logic          rst_n,
    bpd_cfg_if.sink       cfg,
    output bpd_pkg::cfg_t cfg_q
);
    import bpd_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg.ready = 1'b1;
    assign cfg_q     = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg.valid)
        begin
            case (reg_sel_t'(cfg.index))
                REG_LADDER_MODE: cfg_next.ladder_mode = cfg.data[0];
                REG_LEVEL_NONE:  cfg_next.level_none  = cfg.data;
                REG_LEVEL_FOUR:  cfg_next.level_four  = cfg.data;
                REG_LEVEL_THREE: cfg_next.level_three = cfg.data;
                REG_LEVEL_TWO:   cfg_next.level_two   = cfg.data;
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

/* hdl/bpd_decode.sv */
module bpd_decode (
    input  logic             clk,
    input  logic             rst_n,
    input  bpd_pkg::cfg_t    cfg,
    input  logic             advance,
    input  bpd_pkg::sample_t ladder_sample,
    input  logic             pin_level,
    output bpd_pkg::code_t   button_code
);
    import bpd_pkg::*;

    logic   press_active_reg;
    logic   press_active_next;
    count_t hold_count_reg;
    count_t hold_count_next;
    logic   long_reported_reg;
    logic   long_reported_next;
    code_t  ladder_code;
    code_t  pin_code;
    logic   pressed;
    logic   below_limit;

    assign pressed     = ~pin_level;
    assign below_limit = hold_count_reg < LONG_PRESS_TICKS;

    // The thresholds are tested in a fixed order and the first match wins.
    always_comb
    begin
        if (ladder_sample > cfg.level_none)
        begin
            ladder_code = CODE_NONE;
        end
        else if (ladder_sample > cfg.level_four)
        begin
            ladder_code = CODE_BTN4;
        end
        else if (ladder_sample > cfg.level_three)
        begin
            ladder_code = CODE_BTN3;
        end
        else if (ladder_sample > cfg.level_two)
        begin
            ladder_code = CODE_BTN2;
        end
        else
        begin
            ladder_code = CODE_BTN1;
        end
    end

    always_comb
    begin
        press_active_next  = press_active_reg;
        hold_count_next    = hold_count_reg;
        long_reported_next = long_reported_reg;
        pin_code           = CODE_NONE;
        if (!press_active_reg)
        begin
            if (pressed)
            begin
                press_active_next  = 1'b1;
                hold_count_next    = '0;
                long_reported_next = 1'b0;
                pin_code           = CODE_HELD;
            end
        end
        else if (!pressed)
        begin
            pin_code           = (!long_reported_reg && below_limit) ? CODE_SHORT : CODE_NONE;
            press_active_next  = 1'b0;
            hold_count_next    = '0;
            long_reported_next = 1'b0;
        end
        else if (!long_reported_reg && !below_limit)
        begin
            long_reported_next = 1'b1;
            pin_code           = CODE_LONG;
        end
        else
        begin
            if (!long_reported_reg && below_limit)
            begin
                hold_count_next = hold_count_reg + count_t'(1);
            end
            pin_code = CODE_HELD;
        end
    end

    assign button_code = cfg.ladder_mode ? ladder_code : pin_code;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            press_active_reg  <= 1'b0;
            hold_count_reg    <= '0;
            long_reported_reg <= 1'b0;
        end
        else if (advance && !cfg.ladder_mode)
        begin
            press_active_reg  <= press_active_next;
            hold_count_reg    <= hold_count_next;
            long_reported_reg <= long_reported_next;
        end
    end

endmodule

/* hdl/button_press_decoder.sv */
// Channel  Role    Transaction payload
// tick     sink    ladder_sample[7:0], pin_level
// code     source  button_code[2:0]
// cfg      sink    index[2:0], data[7:0]
//
// A tick is registered in stage 1 on acceptance and its code is registered in the
// output register as stage 1 advances; one tick is accepted every cycle unless code stalls.
// The press state is updated once per tick in pin mode, as the tick leaves stage 1.
// Reset clears the valid flags, the press state and the mode bit, and loads the
// threshold registers with their default levels.
// A stalled code holds the stage behind it; tick.ready stays high while code.ready is high.
// Configuration writes are always taken, one per cycle.
module button_press_decoder (
    input  logic      clk,
    input  logic      rst_n,
    bpd_in_if.sink    tick,
    bpd_out_if.source code,
    bpd_cfg_if.sink   cfg
);
    import bpd_pkg::*;

    cfg_t    cfg_q;
    logic    s1_valid_reg;
    logic    s1_valid_next;
    sample_t s1_sample_reg;
    logic    s1_pin_reg;
    logic    out_valid_reg;
    logic    out_valid_next;
    code_t   out_code_reg;
    code_t   stage_code;
    logic    out_free;
    logic    advance;
    logic    tick_fire;

    assign out_free   = !out_valid_reg || code.ready;
    assign advance    = s1_valid_reg && out_free;
    assign tick.ready = !s1_valid_reg || out_free;
    assign tick_fire  = tick.valid && tick.ready;

    assign code.valid       = out_valid_reg;
    assign code.button_code = out_code_reg;

    bpd_cfg_regs u_cfg_regs (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .cfg_q (cfg_q)
    );

    bpd_decode u_decode (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg_q),
        .advance       (advance),
        .ladder_sample (s1_sample_reg),
        .pin_level     (s1_pin_reg),
        .button_code   (stage_code)
    );

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (tick_fire)
        begin
            s1_valid_next = 1'b1;
        end
        else if (advance)
        begin
            s1_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (code.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (tick_fire)
        begin
            s1_sample_reg <= tick.ladder_sample;
            s1_pin_reg    <= tick.pin_level;
        end
        if (advance)
        begin
            out_code_reg <= stage_code;
        end
    end

endmodule

/* hdl/bpd_checker.sv */
module bpd_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       tick_valid,
    input logic                       tick_ready,
    input logic                       code_valid,
    input logic                       code_ready,
    input logic [bpd_pkg::CODE_W-1:0] button_code
);
    import bpd_pkg::*;

    // A stalled code transaction keeps its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        code_valid && !code_ready |=> code_valid && $stable(button_code))
        else $error("code payload changed while stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        code_valid |-> button_code <= CODE_BTN4)
        else $error("button code out of range");

    // Once an accepted tick has passed stage 1 and the output register, a code is pending.
    assert property (@(posedge clk) disable iff (!rst_n)
        tick_valid && tick_ready |-> ##2 code_valid)
        else $error("code missing two cycles after tick");

    // The tick side never stalls while the code side is taking transactions.
    assert property (@(posedge clk) disable iff (!rst_n)
        code_ready |-> tick_ready)
        else $error("tick stalled while code side ready");

endmodule

bind button_press_decoder bpd_checker u_bpd_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .tick_valid  (tick.valid),
    .tick_ready  (tick.ready),
    .code_valid  (code.valid),
    .code_ready  (code.ready),
    .button_code (code.button_code)
);

/* dv/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
    import bpd_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int HOLD_CYCLES  = 64;
    localparam int SETTLE       = 6;
    localparam int LONG_TICKS   = LONG_PRESS_TICKS;
    localparam int MAX_REPORTS  = 100;

    localparam logic PIN_PRESSED  = 1'b0;
    localparam logic PIN_RELEASED = 1'b1;

    localparam reg_index_t REG_SPARE_LO = 3'd5;
    localparam reg_index_t REG_SPARE_HI = 3'd7;

    typedef struct packed {
        sample_t ladder_sample;
        logic    pin_level;
    } tick_item_t;

    logic clk;
    logic rst_n;

    bpd_in_if  tick_if ();
    bpd_out_if code_if ();
    bpd_cfg_if cfg_if ();

    button_press_decoder dut (
        .clk   (clk),
        .rst_n (rst_n),
        .tick  (tick_if),
        .code  (code_if),
        .cfg   (cfg_if)
    );

    tick_item_t pending_ticks[$];
    code_t      expected_codes[$];

    cfg_t   model_cfg;
    logic   pressing;
    count_t held_ticks;
    logic   long_given;

    int  errors;
    int  cycle_count;
    int  tick_gap;
    int  ready_gap;
    bit  calm;
    bit  squeeze_go;
    logic long_hold;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic int draw_wait();
        if (calm)
            return 0;
        return $urandom_range(0, 9);
    endfunction

    function automatic code_t predict_code(sample_t s, logic pin);
        logic  pressed;
        code_t c;
        pressed = (pin == PIN_PRESSED);
        if (model_cfg.ladder_mode)
        begin
            if (s > model_cfg.level_none)
                c = CODE_NONE;
            else if (s > model_cfg.level_four)
                c = CODE_BTN4;
            else if (s > model_cfg.level_three)
                c = CODE_BTN3;
            else if (s > model_cfg.level_two)
                c = CODE_BTN2;
            else
                c = CODE_BTN1;
        end
        else if (!pressing)
        begin
            if (pressed)
            begin
                pressing   = 1'b1;
                held_ticks = '0;
                long_given = 1'b0;
                c = CODE_HELD;
            end
            else
                c = CODE_NONE;
        end
        else if (!pressed)
        begin
            c = (!long_given && held_ticks < LONG_PRESS_TICKS) ? CODE_SHORT : CODE_NONE;
            pressing   = 1'b0;
            held_ticks = '0;
            long_given = 1'b0;
        end
        else if (!long_given && held_ticks >= LONG_PRESS_TICKS)
        begin
            long_given = 1'b1;
            c = CODE_LONG;
        end
        else
        begin
            if (!long_given && held_ticks < LONG_PRESS_TICKS)
                held_ticks = held_ticks + 1'b1;
            c = CODE_HELD;
        end
        return c;
    endfunction

    task automatic report_mismatch(string what);
        if (errors < MAX_REPORTS)
            $display("ERROR at %0t: %s", $time, what);
        errors++;
    endtask

    // Tick driver: offers queued ticks and predicts the code of each accepted one.
    always @(posedge clk or negedge rst_n)
    begin
        tick_item_t item;
        if (!rst_n)
        begin
            tick_if.valid <= 1'b0;
            tick_gap      <= 0;
        end
        else
        begin
            if (tick_if.valid && tick_if.ready)
                expected_codes.push_back(predict_code(tick_if.ladder_sample, tick_if.pin_level));
            if (!tick_if.valid || tick_if.ready)
            begin
                if (tick_gap != 0)
                begin
                    tick_if.valid <= 1'b0;
                    tick_gap      <= tick_gap - 1;
                end
                else if (pending_ticks.size() != 0)
                begin
                    item = pending_ticks.pop_front();
                    tick_if.valid         <= 1'b1;
                    tick_if.ladder_sample <= item.ladder_sample;
                    tick_if.pin_level     <= item.pin_level;
                    tick_gap              <= draw_wait();
                end
                else
                    tick_if.valid <= 1'b0;
            end
        end
    end

    // Code monitor: checks each accepted code against the oldest prediction.
    always @(posedge clk or negedge rst_n)
    begin
        code_t want;
        int    wait_left;
        if (!rst_n)
        begin
            code_if.ready <= 1'b0;
            ready_gap     <= 0;
        end
        else
        begin
            if (code_if.valid && code_if.ready)
            begin
                if (expected_codes.size() == 0)
                    report_mismatch($sformatf("code %0d arrived with none pending",
                                              code_if.button_code));
                else
                begin
                    want = expected_codes.pop_front();
                    if (code_if.button_code !== want)
                        report_mismatch($sformatf("button_code %0d, predicted %0d",
                                                  code_if.button_code, want));
                end
                wait_left = draw_wait();
            end
            else if (ready_gap != 0)
                wait_left = ready_gap - 1;
            else
                wait_left = 0;
            ready_gap     <= wait_left;
            code_if.ready <= (wait_left == 0) && !long_hold;
        end
    end

    // Long receiver stall so that the pipeline fills and pushes back on ticks.
    initial
    begin
        long_hold = 1'b0;
        wait (squeeze_go);
        @(posedge clk);
        long_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        long_hold <= 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    task automatic push_tick(sample_t s, logic pin);
        tick_item_t item;
        item.ladder_sample = s;
        item.pin_level     = pin;
        pending_ticks.push_back(item);
    endtask

    task automatic push_press(int len);
        repeat (len) push_tick(sample_t'($urandom_range(0, 255)), PIN_PRESSED);
        push_tick(sample_t'($urandom_range(0, 255)), PIN_RELEASED);
    endtask

    task automatic write_reg(reg_index_t idx, reg_data_t value);
        @(posedge clk);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= value;
        @(posedge clk);
        while (!cfg_if.ready)
            @(posedge clk);
        case (idx)
            REG_LADDER_MODE: model_cfg.ladder_mode = value[0];
            REG_LEVEL_NONE:  model_cfg.level_none  = value;
            REG_LEVEL_FOUR:  model_cfg.level_four  = value;
            REG_LEVEL_THREE: model_cfg.level_three = value;
            REG_LEVEL_TWO:   model_cfg.level_two   = value;
            default: ;
        endcase
        cfg_if.valid <= 1'b0;
    endtask

    task automatic set_levels(reg_data_t none_lvl, reg_data_t four_lvl,
                              reg_data_t three_lvl, reg_data_t two_lvl);
        write_reg(REG_LEVEL_NONE, none_lvl);
        write_reg(REG_LEVEL_FOUR, four_lvl);
        write_reg(REG_LEVEL_THREE, three_lvl);
        write_reg(REG_LEVEL_TWO, two_lvl);
    endtask

    task automatic wait_idle();
        while (pending_ticks.size() != 0 || tick_if.valid || expected_codes.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic fill_random(int n);
        int      made;
        int      len;
        sample_t lvl;
        made = 0;
        while (made < n)
        begin
            if (model_cfg.ladder_mode)
            begin
                case ($urandom_range(0, 5))
                    0: lvl = model_cfg.level_none;
                    1: lvl = model_cfg.level_four;
                    2: lvl = model_cfg.level_three;
                    3: lvl = model_cfg.level_two;
                    default: lvl = sample_t'($urandom_range(0, 255));
                endcase
                push_tick(sample_t'(lvl + $urandom_range(0, 2) - 1),
                          logic'($urandom_range(0, 1)));
                made++;
            end
            else if ($urandom_range(0, 9) < 8)
            begin
                case ($urandom_range(0, 3))
                    0: len = $urandom_range(1, LONG_TICKS);
                    1: len = LONG_TICKS + 1;
                    2: len = LONG_TICKS + 2;
                    default: len = $urandom_range(LONG_TICKS + 3, 2 * LONG_TICKS + 4);
                endcase
                push_press(len);
                made += len + 1;
                repeat ($urandom_range(0, 2))
                begin
                    push_tick(sample_t'($urandom_range(0, 255)), PIN_RELEASED);
                    made++;
                end
            end
            else
            begin
                repeat ($urandom_range(1, 6))
                begin
                    push_tick(sample_t'($urandom_range(0, 255)), logic'($urandom_range(0, 1)));
                    made++;
                end
            end
        end
    endtask

    task automatic run_phase(int n, bit no_idle);
        calm = no_idle;
        fill_random(n);
        wait_idle();
    endtask

    initial
    begin
        rst_n = 1'b0;
        tick_if.valid         = 1'b0;
        tick_if.ladder_sample = '0;
        tick_if.pin_level     = PIN_RELEASED;
        code_if.ready         = 1'b0;
        cfg_if.valid          = 1'b0;
        cfg_if.index          = '0;
        cfg_if.data           = '0;
        model_cfg   = CFG_RESET;
        pressing    = 1'b0;
        held_ticks  = '0;
        long_given  = 1'b0;
        errors      = 0;
        cycle_count = 0;
        calm        = 1'b0;
        squeeze_go  = 1'b0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // A press started in pin mode must survive a detour through ladder mode.
        push_tick(8'h00, PIN_PRESSED);
        wait_idle();
        write_reg(REG_LADDER_MODE, 8'h01);
        push_tick(8'hFF, PIN_PRESSED);
        push_tick(CFG_RESET.level_none + 1'b1, PIN_RELEASED);
        push_tick(CFG_RESET.level_none, PIN_PRESSED);
        push_tick(CFG_RESET.level_four + 1'b1, PIN_RELEASED);
        push_tick(CFG_RESET.level_three + 1'b1, PIN_PRESSED);
        push_tick(CFG_RESET.level_two + 1'b1, PIN_RELEASED);
        push_tick(CFG_RESET.level_two, PIN_PRESSED);
        push_tick(8'h00, PIN_RELEASED);
        wait_idle();
        write_reg(REG_LADDER_MODE, 8'h02);
        push_tick(8'h80, PIN_RELEASED);
        push_press(LONG_TICKS + 1);
        push_press(LONG_TICKS + 2);
        wait_idle();

        run_phase(200, 1'b0);

        write_reg(REG_SPARE_LO, 8'hFF);
        write_reg(REG_SPARE_HI, 8'h00);
        write_reg(REG_LADDER_MODE, 8'hFF);
        run_phase(200, $urandom_range(0, 3) == 0);

        set_levels(8'h00, 8'h00, 8'h00, 8'h00);
        run_phase(100, 1'b0);

        set_levels(8'hFF, 8'hFF, 8'hFF, 8'hFF);
        run_phase(100, $urandom_range(0, 3) == 0);

        set_levels(8'd60, 8'd200, 8'd30, 8'd128);
        run_phase(150, 1'b0);

        repeat (2)
        begin
            set_levels(reg_data_t'($urandom_range(0, 255)), reg_data_t'($urandom_range(0, 255)),
                       reg_data_t'($urandom_range(0, 255)), reg_data_t'($urandom_range(0, 255)));
            run_phase(100, $urandom_range(0, 3) == 0);
        end

        write_reg(REG_LADDER_MODE, 8'h00);
        squeeze_go = 1'b1;
        run_phase(250, 1'b1);

        run_phase(200, 1'b0);

        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

/* files.f */
hdl/bpd_pkg.sv
hdl/bpd_in_if.sv
hdl/bpd_out_if.sv
hdl/bpd_cfg_if.sv
hdl/bpd_cfg_regs.sv
hdl/bpd_decode.sv
hdl/button_press_decoder.sv
hdl/bpd_checker.sv
dv/tb_top.sv
